// File: rtl/nhs_pkg.sv
// Shared constants, codes and types of the neighbor history steering block.
`default_nettype none

package nhs_pkg;

   // Ring size and the widths that follow from it.
   localparam int HISTORY_DEPTH = 8;
   localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
   localparam int SUM_W = $clog2(HISTORY_DEPTH * 255 + 1);
   localparam int DIV_STEPS = (SUM_W + 1) / 2;
   localparam int DIV_W = 2 * DIV_STEPS;
   localparam int STEP_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_ID       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FENCE_ID        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FENCE_RANGE     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ANONYMOUS_ID    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BOUND_TOLERANCE = 3'd4;

   localparam logic [7:0] TOL_RESET  = 8'd2;
   localparam logic [7:0] SLOT_EMPTY = 8'hFF;

   // Item operations.
   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   // Steering commands.
   localparam logic [1:0] CMD_NONE = 2'd0;
   localparam logic [1:0] CMD_FWD  = 2'd1;
   localparam logic [1:0] CMD_CW   = 2'd2;
   localparam logic [1:0] CMD_CCW  = 2'd3;

   // Steering ladder thresholds.
   localparam logic [7:0]        ORBIT_CW_MAX  = 8'd40;
   localparam logic [7:0]        ORBIT_FWD_LIM = 8'd45;
   localparam logic signed [7:0] DIFF_FWD_MAX  = -8'sd2;
   localparam logic signed [7:0] DIFF_CCW_NEAR = 8'sd8;
   localparam logic signed [7:0] DIFF_CW_MID   = 8'sd18;
   localparam logic signed [7:0] DIFF_CCW_FAR  = 8'sd28;
   localparam logic signed [7:0] DIFF_CW_FAR   = 8'sd48;

   typedef struct packed {
      logic [7:0] target_id;
      logic [7:0] fence_id;
      logic [7:0] fence_range;
      logic [7:0] anonymous_id;
      logic [7:0] bound_tolerance;
   } cfg_type;

   typedef struct packed {
      logic       op;
      logic [7:0] sender_id;
      logic [7:0] gradient;
      logic [7:0] distance;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

   typedef struct packed {
      logic       full_res;
      logic [7:0] top_gradient;
      logic       heard_target;
      logic       on_bound;
      logic [1:0] steer_cmd;
   } result_type;

endpackage

`default_nettype wire

// File: rtl/nhs_front.sv
// Input side: classifies items and holds them in a two-entry queue.
`default_nettype none

module nhs_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [23:0]           req_tdata,
   input  wire logic                  req_tuser,
   output nhs_pkg::queue_head_type    head,
   input  wire logic                  pop
);

   nhs_pkg::item_type mem_ff [2];
   logic              wr_ff, wr_in;
   logic              rd_ff, rd_in;
   logic [1:0]        count_ff, count_in;
   nhs_pkg::item_type item;
   logic              push;

   // The kind flag picks the operation; the payload is kept as is.
   always_comb begin
      item.op        = req_tuser ? nhs_pkg::OP_CLEAR : nhs_pkg::OP_ADD;
      item.sender_id = req_tdata[7:0];
      item.gradient  = req_tdata[15:8];
      item.distance  = req_tdata[23:16];
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign head.valid = (count_ff != 2'd0);
   assign head.item  = mem_ff[rd_ff];

   always_comb begin
      wr_in    = push ? ~wr_ff : wr_ff;
      rd_in    = pop ? ~rd_ff : rd_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= item;
      end
   end

endmodule

`default_nettype wire

// File: rtl/nhs_back.sv
// Work side: updates the history ring, walks its slots, divides and steers.
`default_nettype none

module nhs_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire nhs_pkg::cfg_type      cfg,
   input  wire nhs_pkg::queue_head_type head,
   output logic                       pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output nhs_pkg::result_type        rsp_result
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_DIV_A = 3'd2;
   localparam logic [2:0] ST_DIV_B = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   localparam int D = nhs_pkg::HISTORY_DEPTH;
   localparam int PW = nhs_pkg::PTR_W;
   localparam int CW = nhs_pkg::CNT_W;
   localparam int SW = nhs_pkg::SUM_W;
   localparam int DW = nhs_pkg::DIV_W;
   localparam int TW = nhs_pkg::STEP_W;

   logic [2:0]     state_ff, state_in;
   logic [7:0]     slot_id_ff [D];
   logic [7:0]     slot_dist_ff [D];
   logic [D-1:0]   valid_ff, valid_in;
   logic [PW-1:0]  wptr_ff, wptr_in;
   logic [7:0]     top_ff, top_in;
   logic [PW-1:0]  scan_ff, scan_in;
   logic [SW-1:0]  sum_a_ff, sum_a_in, sum_b_ff, sum_b_in;
   logic [CW-1:0]  cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic [7:0]     min_ff, min_in;
   logic           heard_ff, heard_in;
   logic [7:0]     avg_a_ff, avg_a_in, avg_b_ff, avg_b_in;
   logic [DW-1:0]  dvd_ff, dvd_in, quo_ff, quo_in;
   logic [CW-1:0]  rem_ff, rem_in, dvs_ff, dvs_in;
   logic [TW-1:0]  step_ff, step_in;
   logic           rsp_valid_ff, rsp_valid_in;
   nhs_pkg::result_type rsp_ff, rsp_in;

   logic           slot_we;
   logic           anon;
   logic           rd_valid;
   logic [7:0]     rd_id, rd_dist;
   logic           match_a, match_b;
   logic [SW-1:0]  sum_a_nx, sum_b_nx;
   logic [CW-1:0]  cnt_a_nx, cnt_b_nx;
   logic [CW:0]    r1, r1s, r2, r2s;
   logic           ge1, ge2;
   logic [DW-1:0]  quo_nx;
   logic           div_last;
   nhs_pkg::result_type res;
   logic [8:0]     err;
   logic [7:0]     err_abs;
   logic [7:0]     avg_b_use, base;
   logic signed [7:0] diff;
   logic           out_free;

   assign anon       = (cfg.fence_id == cfg.anonymous_id);
   assign pop        = (state_ff == ST_IDLE) && head.valid;
   assign slot_we    = pop && (head.item.op == nhs_pkg::OP_ADD);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // Slots that are not valid read as their cleared contents.
   assign rd_valid = valid_ff[scan_ff];
   assign rd_id    = rd_valid ? slot_id_ff[scan_ff] : nhs_pkg::SLOT_EMPTY;
   assign rd_dist  = rd_valid ? slot_dist_ff[scan_ff] : nhs_pkg::SLOT_EMPTY;
   assign match_a  = anon || (cfg.fence_id == rd_id);
   assign match_b  = (cfg.fence_id == rd_id);
   assign sum_a_nx = sum_a_ff + (match_a ? SW'(rd_dist) : SW'(0));
   assign sum_b_nx = sum_b_ff + (match_b ? SW'(rd_dist) : SW'(0));
   assign cnt_a_nx = cnt_a_ff + CW'(match_a);
   assign cnt_b_nx = cnt_b_ff + CW'(match_b);

   // Restoring division, two quotient bits per cycle.
   always_comb begin
      r1     = {rem_ff, dvd_ff[DW-1]};
      ge1    = (r1 >= {1'b0, dvs_ff});
      r1s    = ge1 ? (r1 - {1'b0, dvs_ff}) : r1;
      r2     = {r1s[CW-1:0], dvd_ff[DW-2]};
      ge2    = (r2 >= {1'b0, dvs_ff});
      r2s    = ge2 ? (r2 - {1'b0, dvs_ff}) : r2;
      quo_nx = {quo_ff[DW-3:0], ge1, ge2};
   end
   assign div_last = (step_ff == TW'(nhs_pkg::DIV_STEPS - 1));

   // Result of the finished walk.
   always_comb begin
      res.full_res     = &valid_ff;
      res.top_gradient = top_ff;
      res.heard_target = heard_ff;
      err     = {1'b0, cfg.fence_range} - {1'b0, avg_a_ff};
      err_abs = err[8] ? 8'(-err) : err[7:0];
      if ((cnt_a_ff < CW'(2)) || (sum_a_ff == '0)) begin
         res.on_bound = 1'b0;
      end else begin
         res.on_bound = (err_abs <= cfg.bound_tolerance);
      end
      avg_b_use = (cnt_b_ff == '0) ? 8'd0 : avg_b_ff;
      base      = anon ? min_ff : avg_b_use;
      diff      = $signed(base - cfg.fence_range);
      priority if (anon && (min_ff <= nhs_pkg::ORBIT_CW_MAX)) begin
         res.steer_cmd = nhs_pkg::CMD_CW;
      end else if (anon && (min_ff < nhs_pkg::ORBIT_FWD_LIM)) begin
         res.steer_cmd = nhs_pkg::CMD_FWD;
      end else if (diff <= nhs_pkg::DIFF_FWD_MAX) begin
         res.steer_cmd = nhs_pkg::CMD_FWD;
      end else if (diff == -8'sd1) begin
         res.steer_cmd = nhs_pkg::CMD_CW;
      end else if (diff == 8'sd0) begin
         res.steer_cmd = nhs_pkg::CMD_FWD;
      end else if (diff == 8'sd1) begin
         res.steer_cmd = nhs_pkg::CMD_CW;
      end else if (diff <= nhs_pkg::DIFF_CCW_NEAR) begin
         res.steer_cmd = nhs_pkg::CMD_CCW;
      end else if (diff <= nhs_pkg::DIFF_CW_MID) begin
         res.steer_cmd = nhs_pkg::CMD_CW;
      end else if (diff <= nhs_pkg::DIFF_CCW_FAR) begin
         res.steer_cmd = nhs_pkg::CMD_CCW;
      end else if (diff <= nhs_pkg::DIFF_CW_FAR) begin
         res.steer_cmd = nhs_pkg::CMD_CW;
      end else begin
         res.steer_cmd = nhs_pkg::CMD_NONE;
      end
   end

   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      wptr_in      = wptr_ff;
      top_in       = top_ff;
      scan_in      = scan_ff;
      sum_a_in     = sum_a_ff;
      sum_b_in     = sum_b_ff;
      cnt_a_in     = cnt_a_ff;
      cnt_b_in     = cnt_b_ff;
      min_in       = min_ff;
      heard_in     = heard_ff;
      avg_a_in     = avg_a_ff;
      avg_b_in     = avg_b_ff;
      dvd_in       = dvd_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      step_in      = step_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               if (head.item.op == nhs_pkg::OP_CLEAR) begin
                  valid_in = '0;
                  wptr_in  = '0;
                  top_in   = 8'd0;
               end else begin
                  valid_in[wptr_ff] = 1'b1;
                  wptr_in = (wptr_ff == PW'(D - 1)) ? PW'(0) : wptr_ff + PW'(1);
                  if (top_ff < head.item.gradient) begin
                     top_in = head.item.gradient;
                  end
               end
               scan_in  = '0;
               sum_a_in = '0;
               sum_b_in = '0;
               cnt_a_in = '0;
               cnt_b_in = '0;
               min_in   = 8'hFF;
               heard_in = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            sum_a_in = sum_a_nx;
            sum_b_in = sum_b_nx;
            cnt_a_in = cnt_a_nx;
            cnt_b_in = cnt_b_nx;
            min_in   = (rd_dist < min_ff) ? rd_dist : min_ff;
            heard_in = heard_ff || (rd_valid && (rd_id == cfg.target_id));
            scan_in  = scan_ff + PW'(1);
            if (scan_ff == PW'(D - 1)) begin
               dvd_in   = DW'(sum_a_nx);
               dvs_in   = cnt_a_nx;
               rem_in   = '0;
               quo_in   = '0;
               step_in  = '0;
               state_in = ST_DIV_A;
            end
         end
         ST_DIV_A: begin
            dvd_in  = dvd_ff << 2;
            rem_in  = r2s[CW-1:0];
            quo_in  = quo_nx;
            step_in = step_ff + TW'(1);
            if (div_last) begin
               avg_a_in = quo_nx[7:0];
               dvd_in   = DW'(sum_b_ff);
               dvs_in   = cnt_b_ff;
               rem_in   = '0;
               quo_in   = '0;
               step_in  = '0;
               state_in = ST_DIV_B;
            end
         end
         ST_DIV_B: begin
            dvd_in  = dvd_ff << 2;
            rem_in  = r2s[CW-1:0];
            quo_in  = quo_nx;
            step_in = step_ff + TW'(1);
            if (div_last) begin
               avg_b_in = quo_nx[7:0];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_in       = res;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         wptr_ff      <= '0;
         top_ff       <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         wptr_ff      <= wptr_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff  <= scan_in;
      sum_a_ff <= sum_a_in;
      sum_b_ff <= sum_b_in;
      cnt_a_ff <= cnt_a_in;
      cnt_b_ff <= cnt_b_in;
      min_ff   <= min_in;
      heard_ff <= heard_in;
      avg_a_ff <= avg_a_in;
      avg_b_ff <= avg_b_in;
      dvd_ff   <= dvd_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      dvs_ff   <= dvs_in;
      step_ff  <= step_in;
      rsp_ff   <= rsp_in;
      if (slot_we) begin
         slot_id_ff[wptr_ff]   <= head.item.sender_id;
         slot_dist_ff[wptr_ff] <= head.item.distance;
      end
   end

endmodule

`default_nettype wire

// File: rtl/neighbor_history_steering_core.sv
// Top level of the neighbor history steering block: ports, registers, checks.
`default_nettype none

// Channel   Direction  Signals                         Carries
// req       in         req_tvalid/tready/tdata/tuser   one add or clear item
// rsp       out        rsp_tvalid/tready/tdata         one result item per input item
// csr       in         csr_we/csr_index/csr_wdata      register writes, no read-back
//
// An item waits in a two-entry queue until the back end takes it. From there it
// goes through these steps in order: it updates the ring, walks each slot in
// turn, runs the shared divider twice, and forms the result. The back end holds
// one item. There is no clearing pass after a synchronous reset, since slots
// that are not valid read as the cleared contents. A stalled result waits in
// the output register while the next item is already being worked on.

module neighbor_history_steering_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // Input item channel.
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // sender_id [7:0], gradient [15:8], distance [23:16]
   input  wire logic [23:0]                   req_tdata,
   // kind [0]
   input  wire logic                          req_tuser,
   // Result item channel.
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // full_res [0], top_gradient [8:1], heard_target [9], on_bound [10],
   // steer_cmd [12:11], zero [15:13]
   output logic [15:0]                        rsp_tdata,
   // Configuration write port.
   input  wire logic                          csr_we,
   input  wire logic [nhs_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [7:0]                    csr_wdata
);

   nhs_pkg::cfg_type        cfg_ff, cfg_in;
   nhs_pkg::queue_head_type head;
   nhs_pkg::result_type     result;
   logic                    pop;

   // Register writes take effect on the following cycle; indexes past the list are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            nhs_pkg::CSR_TARGET_ID:       cfg_in.target_id       = csr_wdata;
            nhs_pkg::CSR_FENCE_ID:        cfg_in.fence_id        = csr_wdata;
            nhs_pkg::CSR_FENCE_RANGE:     cfg_in.fence_range     = csr_wdata;
            nhs_pkg::CSR_ANONYMOUS_ID:    cfg_in.anonymous_id    = csr_wdata;
            nhs_pkg::CSR_BOUND_TOLERANCE: cfg_in.bound_tolerance = csr_wdata;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_id       <= 8'd0;
         cfg_ff.fence_id        <= 8'd0;
         cfg_ff.fence_range     <= 8'd0;
         cfg_ff.anonymous_id    <= 8'd0;
         cfg_ff.bound_tolerance <= nhs_pkg::TOL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front end accepts and queues items; the back end carries them out.
   nhs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .head       (head),
      .pop        (pop)
   );

   nhs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (result)
   );

   assign rsp_tdata = {3'b000, result.steer_cmd, result.on_bound, result.heard_target,
                       result.top_gradient, result.full_res};

   // The back end only takes an item that the queue actually holds.
   a_pop_has_item: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("back end popped an empty queue");

   // One item is worked on at a time, so two pops never come back to back.
   a_pop_spaced: assert property (@(posedge clock) disable iff (reset)
      pop |=> !pop)
      else $error("back end popped on consecutive cycles");

   // Reset empties the queue, so input is open right after it.
   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("queue not empty after reset");

endmodule

`default_nettype wire
